FILE: design/sstf_pkg.sv
// Shared widths, defaults and control types for the SSTF disk request scheduler.
package sstf_pkg;

  // Fixed widths of the channel fields and the configuration register.
  localparam int unsigned CYL_FIELD_W  = 16;
  localparam int unsigned DIST_FIELD_W = 16;
  localparam int unsigned TOTAL_W      = 22;
  localparam int unsigned START_W      = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_REQUESTS_DEF   = 64;
  localparam int unsigned CYLINDER_WIDTH_DEF = 16;

  // Control strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic wr_en;        // store the incoming request in the addressed cell
    logic mark_en;      // mark the addressed cell as served
    logic clear_marks;  // drop all served marks at batch end
  } cell_ctrl_t;

endpackage

FILE: design/sstf_req_if.sv
// Request channel: one cylinder request per transfer.
interface sstf_req_if;
  logic                                valid;
  logic                                ready;
  logic [sstf_pkg::CYL_FIELD_W-1:0]    request_cylinder;
  logic                                last_request;

  modport source (output valid, output request_cylinder, output last_request, input ready);
  modport sink   (input valid, input request_cylinder, input last_request, output ready);
endinterface

FILE: design/sstf_res_if.sv
// Result channel: one served request per transfer.
interface sstf_res_if;
  logic                                valid;
  logic                                ready;
  logic [sstf_pkg::CYL_FIELD_W-1:0]    served_cylinder;
  logic [sstf_pkg::DIST_FIELD_W-1:0]   seek_distance;
  logic [sstf_pkg::TOTAL_W-1:0]        total_movement;
  logic                                overflowed;
  logic                                last_result;

  modport source (output valid, output served_cylinder, output seek_distance,
                  output total_movement, output overflowed, output last_result,
                  input ready);
  modport sink   (input valid, input served_cylinder, input seek_distance,
                  input total_movement, input overflowed, input last_result,
                  output ready);
endinterface

FILE: design/sstf_cell.sv
// One cell of the scheduler chain: holds a request and refines the passing nearest candidate.
module sstf_cell #(
  parameter int unsigned CW   = sstf_pkg::CYLINDER_WIDTH_DEF,
  parameter int unsigned IW   = 6,
  parameter int unsigned CNTW = 7,
  parameter int unsigned IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sstf_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]        sel_idx,
  input  logic [CW-1:0]        wr_cyl,
  input  logic [CW-1:0]        head,
  input  logic [CNTW-1:0]      count,
  input  logic                 cand_in_valid,
  input  logic                 cand_in_found,
  input  logic [CW-1:0]        cand_in_dist,
  input  logic [IW-1:0]        cand_in_idx,
  input  logic [CW-1:0]        cand_in_cyl,
  output logic                 cand_out_valid,
  output logic                 cand_out_found,
  output logic [CW-1:0]        cand_out_dist,
  output logic [IW-1:0]        cand_out_idx,
  output logic [CW-1:0]        cand_out_cyl
);

  localparam logic [IW-1:0]   MY_IDX = IW'(IDX);
  localparam logic [CNTW-1:0] MY_POS = CNTW'(IDX);

  logic [CW-1:0] cyl;
  logic          served;
  logic          addressed;
  logic          active;
  logic [CW-1:0] gap;
  logic          take;

  assign addressed = (sel_idx == MY_IDX);

  // Stored request; only entries of the current batch are ever compared.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && addressed) begin
      cyl <= wr_cyl;
    end
  end

  // Served mark for this entry.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_marks) begin
      served <= 1'b0;
    end else if (ctrl.mark_en && addressed) begin
      served <= 1'b1;
    end
  end

  // Distance to the head; a strict compare keeps ties with the earlier entry.
  assign active = (MY_POS < count) && !served;
  assign gap    = (cyl >= head) ? (cyl - head) : (head - cyl);
  assign take   = active && (!cand_in_found || (gap < cand_in_dist));

  // Pass the candidate on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out_valid <= 1'b0;
    end else begin
      cand_out_valid <= cand_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cand_out_found <= cand_in_found || take;
    cand_out_dist  <= take ? gap    : cand_in_dist;
    cand_out_idx   <= take ? MY_IDX : cand_in_idx;
    cand_out_cyl   <= take ? cyl    : cand_in_cyl;
  end

endmodule

FILE: design/sstf_disk_request_scheduler_unit.sv
// Top level of the SSTF disk request scheduler: loader, cell chain and result sequencer.
//
// Usage:
//   Requests arrive on the req channel, one cylinder per transfer, up to one per cycle.
//   A transfer with last_request set closes the batch and starts scheduling. Requests
//   beyond MAX_REQUESTS are dropped and flagged on the final result of the batch.
//   For each stored request one result leaves on the res channel, in service order:
//   the cylinder, the seek distance from the previous head position and the running
//   total of head movement. The head starts at start_cylinder, which is written
//   through cfg_wr_en / cfg_wr_data while the block is idle.
//   Each pick sends one candidate down the chain of MAX_REQUESTS cells, one cell per
//   cycle, and the next pick is launched only when the previous result enters the
//   output register.
//   req.ready is high only while loading; it drops from the last request until the
//   final result has entered the output register.
//   When the receiver stalls, the result waits in the output register and the next
//   pick is held until that register frees up.
//   Reset (rst, synchronous) empties the batch, clears the served marks, drops any
//   pending result and sets start_cylinder to zero.
module sstf_disk_request_scheduler_unit #(
  parameter int unsigned MAX_REQUESTS   = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned CYLINDER_WIDTH = sstf_pkg::CYLINDER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sstf_pkg::START_W-1:0]  cfg_wr_data,
  sstf_req_if.sink                      req,
  sstf_res_if.source                    res
);

  localparam int unsigned N    = MAX_REQUESTS;
  localparam int unsigned CW   = CYLINDER_WIDTH;
  localparam int unsigned IW   = $clog2(N);
  localparam int unsigned CNTW = $clog2(N + 1);
  localparam int unsigned TW   = sstf_pkg::TOTAL_W;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                      state;
  logic [sstf_pkg::START_W-1:0] start_cyl;
  logic [CNTW-1:0]             count;
  logic [CNTW-1:0]             served_cnt;
  logic                        ovf_seen;
  logic [CW-1:0]               head;
  logic [TW-1:0]               sum;
  logic                        launch;
  logic [CW-1:0]               pick_dist;
  logic [IW-1:0]               pick_idx;
  logic [CW-1:0]               pick_cyl;

  logic                        in_xfer;
  logic                        has_room;
  logic                        out_free;
  logic                        emit;
  logic                        last_pick;
  logic [TW-1:0]               sum_next;
  sstf_pkg::cell_ctrl_t        ctrl;
  logic [IW-1:0]               sel_idx;
  logic [CW-1:0]               wr_cyl;

  // Candidate links between cells; link 0 feeds the first cell.
  logic                        lk_valid [N+1];
  logic                        lk_found [N+1];
  logic [CW-1:0]               lk_dist  [N+1];
  logic [IW-1:0]               lk_idx   [N+1];
  logic [CW-1:0]               lk_cyl   [N+1];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_cyl <= '0;
    end else if (cfg_wr_en) begin
      start_cyl <= cfg_wr_data;
    end
  end

  // Handshake terms.
  assign req.ready = (state == ST_LOAD);
  assign in_xfer   = req.valid && req.ready;
  assign has_room  = (count < CNTW'(N));
  assign out_free  = !res.valid || res.ready;
  assign emit      = (state == ST_EMIT) && out_free;
  assign last_pick = (CNTW'(served_cnt + 1'b1) == count);
  assign sum_next  = sum + TW'(pick_dist);
  assign wr_cyl    = CW'(req.request_cylinder);

  // Cell control: loads address the fill slot, marks address the picked entry.
  always_comb begin
    ctrl.wr_en       = in_xfer && has_room;
    ctrl.mark_en     = emit;
    ctrl.clear_marks = emit && last_pick;
    sel_idx          = emit ? pick_idx : count[IW-1:0];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      served_cnt <= '0;
      ovf_seen   <= 1'b0;
      launch     <= 1'b0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (has_room) begin
              count <= CNTW'(count + 1'b1);
            end else begin
              ovf_seen <= 1'b1;
            end
            if (req.last_request) begin
              served_cnt <= '0;
              launch     <= 1'b1;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (lk_valid[N]) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            served_cnt <= CNTW'(served_cnt + 1'b1);
            if (last_pick) begin
              count    <= '0;
              ovf_seen <= 1'b0;
              state    <= ST_LOAD;
            end else begin
              launch <= 1'b1;
              state  <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Head position and running total.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      sum  <= '0;
    end else if (in_xfer && req.last_request) begin
      head <= CW'(start_cyl);
      sum  <= '0;
    end else if (emit) begin
      head <= pick_cyl;
      sum  <= sum_next;
    end
  end

  // Capture the winner at the end of the chain.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && lk_valid[N]) begin
      pick_dist <= lk_dist[N];
      pick_idx  <= lk_idx[N];
      pick_cyl  <= lk_cyl[N];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.served_cylinder <= sstf_pkg::CYL_FIELD_W'(pick_cyl);
      res.seek_distance   <= sstf_pkg::DIST_FIELD_W'(pick_dist);
      res.total_movement  <= sum_next;
      res.overflowed      <= last_pick && ovf_seen;
      res.last_result     <= last_pick;
    end
  end

  // Fresh candidate enters the first cell.
  assign lk_valid[0] = launch;
  assign lk_found[0] = 1'b0;
  assign lk_dist[0]  = '0;
  assign lk_idx[0]   = '0;
  assign lk_cyl[0]   = '0;

  // Chain of cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    sstf_cell #(
      .CW   (CW),
      .IW   (IW),
      .CNTW (CNTW),
      .IDX  (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .sel_idx        (sel_idx),
      .wr_cyl         (wr_cyl),
      .head           (head),
      .count          (count),
      .cand_in_valid  (lk_valid[i]),
      .cand_in_found  (lk_found[i]),
      .cand_in_dist   (lk_dist[i]),
      .cand_in_idx    (lk_idx[i]),
      .cand_in_cyl    (lk_cyl[i]),
      .cand_out_valid (lk_valid[i+1]),
      .cand_out_found (lk_found[i+1]),
      .cand_out_dist  (lk_dist[i+1]),
      .cand_out_idx   (lk_idx[i+1]),
      .cand_out_cyl   (lk_cyl[i+1])
    );
  end

`ifndef SYNTHESIS
  // No candidate is in flight while requests are being loaded.
  a_no_scan_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !lk_valid[N])
    else $error("candidate reached chain end during loading");

  // A scan always ends with a pending request found.
  a_scan_finds: assert property (@(posedge clk) disable iff (rst)
    lk_valid[N] |-> lk_found[N])
    else $error("scan ended without a pending request");

  // While scheduling, fewer requests are served than were stored.
  a_served_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> (served_cnt < count))
    else $error("served count reached stored count while scheduling");

  // The picked entry is one of the stored requests.
  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    emit |-> (CNTW'(pick_idx) < count))
    else $error("picked entry beyond stored requests");
`endif

endmodule
